// ----- rtl/core/aldaa_pkg.sv -----
// Package for the accumulator logic and decimal adjust block.
// Holds operation and opcode codes, decoded command and result types.
// No dependencies.
package aldaa_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_LOGIC = 2'd0;
    localparam logic [1:0] OP_CPL   = 2'd1;
    localparam logic [1:0] OP_DAA   = 2'd2;

    localparam logic [7:0] OPC_AND_IMM = 8'hE6;
    localparam logic [7:0] OPC_OR_IMM  = 8'hF6;
    localparam logic [7:0] OPC_XOR_IMM = 8'hEE;
    localparam logic [7:0] OPC_AND_LO  = 8'hA0;
    localparam logic [7:0] OPC_AND_HI  = 8'hA7;
    localparam logic [7:0] OPC_XOR_LO  = 8'hA8;
    localparam logic [7:0] OPC_XOR_HI  = 8'hAF;
    localparam logic [7:0] OPC_OR_LO   = 8'hB0;
    localparam logic [7:0] OPC_OR_HI   = 8'hB7;
    localparam logic [2:0] SRC_HL      = 3'd6;
    localparam logic [2:0] SRC_ACC     = 3'd7;

    localparam logic [3:0] CYC_NONE  = 4'd0;
    localparam logic [3:0] CYC_SHORT = 4'd4;
    localparam logic [3:0] CYC_LONG  = 4'd8;

    localparam logic [7:0] DAA_LOW_CORR  = 8'h06;
    localparam logic [7:0] DAA_HIGH_CORR = 8'h60;
    localparam logic [7:0] DAA_HIGH_MAX  = 8'h99;
    localparam logic [3:0] DAA_LOW_MAX   = 4'h9;

    localparam logic [2:0] KIND_NOP = 3'd0;
    localparam logic [2:0] KIND_AND = 3'd1;
    localparam logic [2:0] KIND_OR  = 3'd2;
    localparam logic [2:0] KIND_XOR = 3'd3;
    localparam logic [2:0] KIND_CPL = 3'd4;
    localparam logic [2:0] KIND_DAA = 3'd5;

    typedef struct packed {
        logic [2:0] kind;
        logic       use_acc;
        logic       imm;
        logic [3:0] cycles;
        logic [7:0] operand;
    } t_cmd;

    typedef struct packed {
        logic       adv;
        logic [3:0] cycles;
        logic       c;
        logic       h;
        logic       n;
        logic       z;
        logic [7:0] acc;
        logic       accepted;
    } t_res;

endpackage

// ----- rtl/core/aldaa_front.sv -----
// Front end: accepts input transfers and decodes them into commands.
// Depends on aldaa_pkg.
module aldaa_front (
    input  logic              i_valid,
    input  logic [1:0]        i_operation,
    input  logic [7:0]        i_opcode,
    input  logic [7:0]        i_operand,
    input  logic              i_q_ready,
    output logic              o_ready,
    output logic              o_push,
    output aldaa_pkg::t_cmd   o_cmd
);

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;

    always_comb begin
        o_cmd.kind    = aldaa_pkg::KIND_NOP;
        o_cmd.use_acc = 1'b0;
        o_cmd.imm     = 1'b0;
        o_cmd.cycles  = aldaa_pkg::CYC_NONE;
        o_cmd.operand = i_operand;
        case (i_operation)
            aldaa_pkg::OP_LOGIC: begin
                if (i_opcode == aldaa_pkg::OPC_AND_IMM || i_opcode == aldaa_pkg::OPC_OR_IMM ||
                    i_opcode == aldaa_pkg::OPC_XOR_IMM) begin
                    o_cmd.imm    = 1'b1;
                    o_cmd.cycles = aldaa_pkg::CYC_LONG;
                    if (i_opcode == aldaa_pkg::OPC_AND_IMM) begin
                        o_cmd.kind = aldaa_pkg::KIND_AND;
                    end else if (i_opcode == aldaa_pkg::OPC_OR_IMM) begin
                        o_cmd.kind = aldaa_pkg::KIND_OR;
                    end else begin
                        o_cmd.kind = aldaa_pkg::KIND_XOR;
                    end
                end else if (i_opcode inside {[aldaa_pkg::OPC_AND_LO:aldaa_pkg::OPC_AND_HI],
                                              [aldaa_pkg::OPC_XOR_LO:aldaa_pkg::OPC_XOR_HI],
                                              [aldaa_pkg::OPC_OR_LO:aldaa_pkg::OPC_OR_HI]}) begin
                    if (i_opcode inside {[aldaa_pkg::OPC_AND_LO:aldaa_pkg::OPC_AND_HI]}) begin
                        o_cmd.kind = aldaa_pkg::KIND_AND;
                    end else if (i_opcode inside {[aldaa_pkg::OPC_XOR_LO:
                                                   aldaa_pkg::OPC_XOR_HI]}) begin
                        o_cmd.kind = aldaa_pkg::KIND_XOR;
                    end else begin
                        o_cmd.kind = aldaa_pkg::KIND_OR;
                    end
                    o_cmd.cycles  = (i_opcode[2:0] == aldaa_pkg::SRC_HL) ?
                                    aldaa_pkg::CYC_LONG : aldaa_pkg::CYC_SHORT;
                    o_cmd.use_acc = (i_opcode[2:0] == aldaa_pkg::SRC_ACC);
                end
            end
            aldaa_pkg::OP_CPL: begin
                o_cmd.kind   = aldaa_pkg::KIND_CPL;
                o_cmd.cycles = aldaa_pkg::CYC_SHORT;
            end
            aldaa_pkg::OP_DAA: begin
                o_cmd.kind   = aldaa_pkg::KIND_DAA;
                o_cmd.cycles = aldaa_pkg::CYC_SHORT;
            end
            default: begin
                o_cmd.kind = aldaa_pkg::KIND_NOP;
            end
        endcase
    end

endmodule

// ----- rtl/core/aldaa_queue.sv -----
// Short command queue between the decoder and the execution unit.
// Depends on aldaa_pkg.
module aldaa_queue #(
    parameter int DEPTH = aldaa_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  aldaa_pkg::t_cmd i_cmd,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output aldaa_pkg::t_cmd o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    aldaa_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   n_wr;
    logic [AW-1:0]   n_rd;
    logic [CW-1:0]   n_count;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (o_ready || i_pop))
        else $error("Command queue written while full.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("Command queue read while empty.");

endmodule

// ----- rtl/core/aldaa_back.sv -----
// Execution unit: holds accumulator and flags; runs one command per cycle
// unless stalled; an output register holds results. Depends on aldaa_pkg.
module aldaa_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  aldaa_pkg::t_cmd i_cmd,
    output logic            o_pop,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output aldaa_pkg::t_res o_res
);

    logic [7:0]      r_acc;
    logic            r_z;
    logic            r_n;
    logic            r_h;
    logic            r_c;
    logic            r_out_valid;
    aldaa_pkg::t_res r_res;
    aldaa_pkg::t_res n_res;

    logic [7:0] src;
    logic       daa_lo;
    logic       daa_hi;
    logic [7:0] daa_corr;

    assign o_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    assign src      = i_cmd.use_acc ? r_acc : i_cmd.operand;
    assign daa_lo   = r_h || (!r_n && (r_acc[3:0] > aldaa_pkg::DAA_LOW_MAX));
    assign daa_hi   = r_c || (!r_n && (r_acc > aldaa_pkg::DAA_HIGH_MAX));
    assign daa_corr = (daa_lo ? aldaa_pkg::DAA_LOW_CORR : 8'h00) |
                      (daa_hi ? aldaa_pkg::DAA_HIGH_CORR : 8'h00);

    always_comb begin
        n_res.accepted = 1'b1;
        n_res.acc      = r_acc;
        n_res.z        = r_z;
        n_res.n        = r_n;
        n_res.h        = r_h;
        n_res.c        = r_c;
        n_res.cycles   = i_cmd.cycles;
        n_res.adv      = i_cmd.imm;
        case (i_cmd.kind)
            aldaa_pkg::KIND_AND: begin
                n_res.acc = r_acc & src;
                n_res.n   = 1'b0;
                n_res.h   = 1'b1;
                n_res.c   = 1'b0;
                n_res.z   = (n_res.acc == 8'h00);
            end
            aldaa_pkg::KIND_OR: begin
                n_res.acc = r_acc | src;
                n_res.n   = 1'b0;
                n_res.h   = 1'b0;
                n_res.c   = 1'b0;
                n_res.z   = (n_res.acc == 8'h00);
            end
            aldaa_pkg::KIND_XOR: begin
                n_res.acc = r_acc ^ src;
                n_res.n   = 1'b0;
                n_res.h   = 1'b0;
                n_res.c   = 1'b0;
                n_res.z   = (n_res.acc == 8'h00);
            end
            aldaa_pkg::KIND_CPL: begin
                n_res.acc = ~r_acc;
                n_res.n   = 1'b1;
                n_res.h   = 1'b1;
            end
            aldaa_pkg::KIND_DAA: begin
                n_res.acc = r_n ? (r_acc - daa_corr) : (r_acc + daa_corr);
                n_res.h   = 1'b0;
                n_res.c   = r_c || daa_hi;
                n_res.z   = (n_res.acc == 8'h00);
            end
            default: begin
                n_res.accepted = 1'b0;
                n_res.cycles   = aldaa_pkg::CYC_NONE;
                n_res.adv      = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_z         <= 1'b0;
            r_n         <= 1'b0;
            r_h         <= 1'b0;
            r_c         <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_acc       <= n_res.acc;
                r_z         <= n_res.z;
                r_n         <= n_res.n;
                r_h         <= n_res.h;
                r_c         <= n_res.c;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    a_state_matches_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_res.acc == r_acc && r_res.z == r_z && r_res.c == r_c))
        else $error("Stored accumulator differs from the delivered result.");

    a_accept_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res.accepted == (r_res.cycles != aldaa_pkg::CYC_NONE)))
        else $error("Accepted flag disagrees with the cycle count.");

    a_adv_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.adv) |-> (r_res.cycles == aldaa_pkg::CYC_LONG))
        else $error("Immediate form reported without a long cycle count.");

endmodule

// ----- rtl/core/accumulator_logic_and_decimal_adjust.sv -----
// An input transfer is stored in the command queue, then its result in the output register.
// Throughput: one item per cycle while the sink does not stall, set by the execution unit.
// A command queue decouples decode from execution; the output register holds
// a result while the sink stalls. Synchronous active-low reset clears the
// accumulator, all four flags, the queue and the output valid flag.
// Depends on aldaa_pkg, aldaa_front, aldaa_queue and aldaa_back.
module accumulator_logic_and_decimal_adjust #(
    parameter int QUEUE_DEPTH = aldaa_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // opcode[7:0], operand[15:8]
    input  logic [1:0]  s_axis_tuser,  // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // accepted[0], accumulator[8:1], zero_flag[9],
                                       // subtract_flag[10], half_carry_flag[11],
                                       // carry_flag[12], cycle_count[16:13],
                                       // advance_pc[17], zero[23:18]
);

    logic            push;
    logic            pop;
    logic            q_ready;
    logic            q_valid;
    aldaa_pkg::t_cmd f_cmd;
    aldaa_pkg::t_cmd q_cmd;
    aldaa_pkg::t_res res;

    aldaa_front u_front (
        .i_valid     (s_axis_tvalid),
        .i_operation (s_axis_tuser),
        .i_opcode    (s_axis_tdata[7:0]),
        .i_operand   (s_axis_tdata[15:8]),
        .i_q_ready   (q_ready),
        .o_ready     (s_axis_tready),
        .o_push      (push),
        .o_cmd       (f_cmd)
    );

    aldaa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    aldaa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_res       (res)
    );

    assign m_axis_tdata = {6'b0, res};

endmodule
